// ===== hw/rtl/addressed_packet_deframer_defines.svh =====
// Assertion macros shared by the deframer RTL.
`ifndef ADDRESSED_PACKET_DEFRAMER_DEFINES_SVH
`define ADDRESSED_PACKET_DEFRAMER_DEFINES_SVH

`ifndef ASSERT_OFF
// Check a property on every clock edge outside reset.
`define APD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check a property on every clock edge, reset included.
`define APD_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define APD_ASSERT(lbl, prop, msg)
`define APD_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== hw/rtl/apd_pkg.sv =====
`timescale 1ns / 1ps

package apd_pkg;

    // Configuration register indexes
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 8;
    localparam logic [CFG_INDEX_W-1:0] REG_OWN_ADDRESS    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_DELIVER_ENABLE = 2'd1;

    // Parser phase, one-hot
    typedef enum logic [4:0] {
        PH_SRC  = 5'b00001,
        PH_DEST = 5'b00010,
        PH_OP   = 5'b00100,
        PH_LEN  = 5'b01000,
        PH_DATA = 5'b10000
    } phase_t;

    // Delivery event codes
    typedef enum logic [1:0] {
        EV_NONE  = 2'd0,
        EV_DATA  = 2'd1,
        EV_EMPTY = 2'd2
    } event_t;

    // One result request
    typedef struct packed {
        event_t      event_res;
        logic [7:0]  src_addr;
        logic [7:0]  dst_addr;
        logic [7:0]  op_code;
        logic [7:0]  frame_length;
        logic [7:0]  byte_index;
        logic [7:0]  payload_byte;
        logic        last;
        logic [15:0] unhandled_count;
    } result_t;

    // Configuration seen by the parser
    typedef struct packed {
        logic [7:0] own_address;
        logic       deliver_enable;
    } cfg_t;

endpackage

// ===== hw/rtl/apd_cfg_regs.sv =====
`timescale 1ns / 1ps

module apd_cfg_regs
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [apd_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [apd_pkg::CFG_DATA_W-1:0]   cfg_data,
    output apd_pkg::cfg_t                    cfg
);

    logic [7:0] own_address_reg;
    logic       deliver_enable_reg;

    // Capture register writes; drop writes to unknown indexes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_address_reg    <= 8'd0;
            deliver_enable_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                apd_pkg::REG_OWN_ADDRESS:
                begin
                    own_address_reg <= cfg_data[7:0];
                end
                apd_pkg::REG_DELIVER_ENABLE:
                begin
                    deliver_enable_reg <= cfg_data[0];
                end
                default:
                begin
                end
            endcase
        end
    end

    assign cfg.own_address    = own_address_reg;
    assign cfg.deliver_enable = deliver_enable_reg;

endmodule

// ===== hw/rtl/apd_parser.sv =====
`timescale 1ns / 1ps

module apd_parser
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [7:0]        rx_byte,
    input  apd_pkg::cfg_t     cfg,
    output apd_pkg::result_t  res
);

    apd_pkg::phase_t phase_reg, phase_next;
    logic [7:0]  src_reg, src_next;
    logic [7:0]  dest_reg, dest_next;
    logic [7:0]  op_reg, op_next;
    logic [7:0]  len_reg, len_next;
    logic [7:0]  seen_reg, seen_next;
    logic [15:0] cnt_reg, cnt_next;

    logic        match;
    logic        bump;
    logic [7:0]  seen_inc;
    apd_pkg::event_t ev;
    logic [7:0]  idx;
    logic [7:0]  pay;
    logic        lst;

    assign match    = (dest_reg == cfg.own_address);
    assign seen_inc = seen_reg + 8'd1;

    // Advance the frame parser by one byte
    always_comb
    begin
        phase_next = phase_reg;
        src_next   = src_reg;
        dest_next  = dest_reg;
        op_next    = op_reg;
        len_next   = len_reg;
        seen_next  = seen_reg;
        bump       = 1'b0;
        ev         = apd_pkg::EV_NONE;
        idx        = 8'd0;
        pay        = 8'd0;
        lst        = 1'b0;
        unique case (phase_reg)
            apd_pkg::PH_DEST:
            begin
                dest_next  = rx_byte;
                phase_next = apd_pkg::PH_OP;
            end
            apd_pkg::PH_OP:
            begin
                op_next    = rx_byte;
                phase_next = apd_pkg::PH_LEN;
            end
            apd_pkg::PH_LEN:
            begin
                len_next  = rx_byte;
                seen_next = 8'd0;
                if (rx_byte == 8'd0)
                begin
                    // Empty frame completes here
                    if (match)
                    begin
                        if (cfg.deliver_enable)
                        begin
                            ev  = apd_pkg::EV_EMPTY;
                            lst = 1'b1;
                        end
                        else
                        begin
                            bump = 1'b1;
                        end
                    end
                    phase_next = apd_pkg::PH_SRC;
                end
                else
                begin
                    phase_next = apd_pkg::PH_DATA;
                end
            end
            apd_pkg::PH_DATA:
            begin
                seen_next = seen_inc;
                if (match && cfg.deliver_enable)
                begin
                    ev  = apd_pkg::EV_DATA;
                    pay = rx_byte;
                    idx = seen_reg;
                end
                if (seen_inc == len_reg)
                begin
                    if (match)
                    begin
                        if (cfg.deliver_enable)
                        begin
                            lst = 1'b1;
                        end
                        else
                        begin
                            bump = 1'b1;
                        end
                    end
                    phase_next = apd_pkg::PH_SRC;
                    seen_next  = 8'd0;
                end
            end
            default:
            begin
                // Source address, also taken on any stray phase code
                src_next   = rx_byte;
                phase_next = apd_pkg::PH_DEST;
            end
        endcase
    end

    // Saturate the unhandled frame counter
    assign cnt_next = (bump && (cnt_reg != 16'hFFFF)) ? (cnt_reg + 16'd1) : cnt_reg;

    // Hold parser state between accepted bytes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= apd_pkg::PH_SRC;
            src_reg   <= 8'd0;
            dest_reg  <= 8'd0;
            op_reg    <= 8'd0;
            len_reg   <= 8'd0;
            seen_reg  <= 8'd0;
            cnt_reg   <= 16'd0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            src_reg   <= src_next;
            dest_reg  <= dest_next;
            op_reg    <= op_next;
            len_reg   <= len_next;
            seen_reg  <= seen_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Build the result request from the updated state
    assign res.event_res       = ev;
    assign res.src_addr        = src_next;
    assign res.dst_addr        = dest_next;
    assign res.op_code         = op_next;
    assign res.frame_length    = len_next;
    assign res.byte_index      = idx;
    assign res.payload_byte    = pay;
    assign res.last            = lst;
    assign res.unhandled_count = cnt_next;

endmodule

// ===== hw/rtl/apd_out_stage.sv =====
`timescale 1ns / 1ps

module apd_out_stage
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  apd_pkg::result_t  res_in,
    input  logic              out_stall,
    output logic              busy,
    output logic              out_valid,
    output apd_pkg::result_t  res_out
);

    logic             valid_reg, valid_next;
    apd_pkg::result_t res_reg;

    // Stage is full while a request waits on a stalled consumer
    assign busy = valid_reg && out_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (valid_reg && !out_stall)
        begin
            valid_next = 1'b0;
        end
    end

    // Track occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Load a new result request
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res_in;
        end
    end

    assign out_valid = valid_reg;
    assign res_out   = res_reg;

endmodule

// ===== hw/rtl/addressed_packet_deframer.sv =====
`timescale 1ns / 1ps
// A byte accepted at a clock edge shows its registered result with out_valid after that edge.
// Throughput: one byte per cycle while in_stall is low; the single result register is reloaded as it drains.
// in_stall rises only while a result is held and out_stall is high.
// Reset (rst_n low, asynchronous) clears the parser to await a source address,
// zeroes headers, index and counter, and clears both configuration registers.
`include "addressed_packet_deframer_defines.svh"

module addressed_packet_deframer
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [apd_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [apd_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [7:0]                       rx_byte,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [1:0]                       event_res,
    output logic [7:0]                       src_addr,
    output logic [7:0]                       dst_addr,
    output logic [7:0]                       op_code,
    output logic [7:0]                       frame_length,
    output logic [7:0]                       byte_index,
    output logic [7:0]                       payload_byte,
    output logic                             last,
    output logic [15:0]                      unhandled_count
);

    apd_pkg::cfg_t    cfg;
    apd_pkg::result_t res_comb;
    apd_pkg::result_t res_q;
    logic             accept;
    logic             busy;
    logic             has_event;
    logic             idle_fields_bad;
    logic [15:0]      cnt_seen;

    assign in_stall = busy;
    assign accept   = in_valid && !busy;

    apd_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    apd_parser u_parser
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .rx_byte (rx_byte),
        .cfg     (cfg),
        .res     (res_comb)
    );

    apd_out_stage u_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (accept),
        .res_in    (res_comb),
        .out_stall (out_stall),
        .busy      (busy),
        .out_valid (out_valid),
        .res_out   (res_q)
    );

    // Drive the result ports
    assign event_res       = res_q.event_res;
    assign src_addr        = res_q.src_addr;
    assign dst_addr        = res_q.dst_addr;
    assign op_code         = res_q.op_code;
    assign frame_length    = res_q.frame_length;
    assign byte_index      = res_q.byte_index;
    assign payload_byte    = res_q.payload_byte;
    assign last            = res_q.last;
    assign unhandled_count = res_q.unhandled_count;

    // Flags for the output checks
    assign has_event       = (event_res != apd_pkg::EV_NONE);
    assign idle_fields_bad = (event_res != apd_pkg::EV_DATA)
                             && ((byte_index != 8'd0) || (payload_byte != 8'd0));
    assign cnt_seen        = unhandled_count;

    `APD_ASSERT_ALWAYS(a_stall_when_full, in_stall |-> out_valid, "stall while empty")
    `APD_ASSERT(a_last_needs_event, (out_valid && last) |-> has_event, "last without delivery")
    `APD_ASSERT(a_idle_fields_zero, !(out_valid && idle_fields_bad), "stray index or payload")
    `APD_ASSERT(a_cnt_up, (out_valid && $past(out_valid)) |-> (cnt_seen >= $past(cnt_seen)), "cnt down")

endmodule
